/* design/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg
// Types and defaults shared by the keyed-record shell sort core.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 64;

    typedef struct packed {
        logic signed [31:0] station_key;
        logic [63:0]        record_payload;
        logic               last_record;
    } ssr_rec_t;

    typedef struct packed {
        logic signed [31:0] sorted_key;
        logic [63:0]        sorted_payload;
        logic               last_out;
        logic               dropped;
    } ssr_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP_INIT,
        ST_GAP_CHK,
        ST_PASS,
        ST_RD,
        ST_CMP,
        ST_SWB,
        ST_PASS_END,
        ST_EMIT,
        ST_FINISH
    } ssr_state_t;

    typedef struct packed {
        logic load;
        logic gap_init;
        logic gap_half;
        logic limit_from_count;
        logic pass_start;
        logic rd_pair;
        logic wr_a;
        logic wr_b;
        logic row_inc;
        logic limit_from_lsr;
        logic emit_init;
        logic emit_rd;
        logic clear;
    } ssr_cmd_t;

    typedef struct packed {
        logic gap_zero;
        logic limit_zero;
        logic greater;
        logic row_end;
        logic swap_seen;
        logic emit_end;
    } ssr_sts_t;

endpackage

/* design/ssr_ctrl.sv */
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: load, gap loop, compare/swap passes, sorted read-out.
// ----------------------------------------------------------------------------
module ssr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_record,
    input  ssr_pkg::ssr_sts_t sts,
    output ssr_pkg::ssr_cmd_t cmd,
    output logic              busy
);

    ssr_pkg::ssr_state_t state_reg;
    ssr_pkg::ssr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ssr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_record)
                    begin
                        state_next = ssr_pkg::ST_GAP_INIT;
                    end
                end
            end
            ssr_pkg::ST_GAP_INIT:
            begin
                cmd.gap_init = 1'b1;
                state_next   = ssr_pkg::ST_GAP_CHK;
            end
            ssr_pkg::ST_GAP_CHK:
            begin
                if (sts.gap_zero)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ssr_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.limit_from_count = 1'b1;
                    state_next           = ssr_pkg::ST_PASS;
                end
            end
            ssr_pkg::ST_PASS:
            begin
                cmd.pass_start = 1'b1;
                if (sts.limit_zero)
                begin
                    cmd.gap_half = 1'b1;
                    state_next   = ssr_pkg::ST_GAP_CHK;
                end
                else
                begin
                    state_next = ssr_pkg::ST_RD;
                end
            end
            ssr_pkg::ST_RD:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = ssr_pkg::ST_CMP;
            end
            ssr_pkg::ST_CMP:
            begin
                if (sts.greater)
                begin
                    cmd.wr_a   = 1'b1;
                    state_next = ssr_pkg::ST_SWB;
                end
                else if (sts.row_end)
                begin
                    state_next = ssr_pkg::ST_PASS_END;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = ssr_pkg::ST_RD;
                end
            end
            ssr_pkg::ST_SWB:
            begin
                cmd.wr_b = 1'b1;
                if (sts.row_end)
                begin
                    state_next = ssr_pkg::ST_PASS_END;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = ssr_pkg::ST_RD;
                end
            end
            ssr_pkg::ST_PASS_END:
            begin
                cmd.limit_from_lsr = 1'b1;
                if (sts.swap_seen)
                begin
                    state_next = ssr_pkg::ST_PASS;
                end
                else
                begin
                    cmd.gap_half = 1'b1;
                    state_next   = ssr_pkg::ST_GAP_CHK;
                end
            end
            ssr_pkg::ST_EMIT:
            begin
                cmd.emit_rd = 1'b1;
                cmd.row_inc = 1'b1;
                if (sts.emit_end)
                begin
                    state_next = ssr_pkg::ST_FINISH;
                end
            end
            ssr_pkg::ST_FINISH:
            begin
                cmd.clear  = 1'b1;
                state_next = ssr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ssr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ssr_pkg::ST_IDLE);

    // second half of a swap always follows the first
    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_b |-> $past(cmd.wr_a))
        else $error("swap write b without preceding write a");

    // every compare is preceded by its read
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssr_pkg::ST_CMP) |-> $past(cmd.rd_pair))
        else $error("compare without pair read");

endmodule

/* design/ssr_dpath.sv */
// ----------------------------------------------------------------------------
// ssr_dpath
// Record store, sort counters, key comparator and result register.
// ----------------------------------------------------------------------------
module ssr_dpath #(
    parameter int DEPTH        = ssr_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssr_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ssr_pkg::ssr_rec_t record,
    input  ssr_pkg::ssr_cmd_t cmd,
    output ssr_pkg::ssr_sts_t sts,
    output logic              result_valid,
    output ssr_pkg::ssr_res_t result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W = KEY_BITS + PAYLOAD_BITS;

    logic [ENT_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic             overflow_reg;
    logic [CNT_W-1:0] gap_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] lsr_reg;
    logic             swap_reg;
    logic [CNT_W-1:0] row_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [ENT_W-1:0] rd_a_reg;
    logic [ENT_W-1:0] rd_b_reg;

    logic [CNT_W-1:0] row_b;
    logic [CNT_W-1:0] row_plus1;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [ENT_W-1:0] load_data;
    logic [KEY_BITS-1:0] key_a;
    logic [KEY_BITS-1:0] key_b;

    assign row_b     = row_reg + gap_reg;
    assign row_plus1 = row_reg + CNT_W'(1);
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign key_a     = rd_a_reg[ENT_W-1 -: KEY_BITS];
    assign key_b     = rd_b_reg[ENT_W-1 -: KEY_BITS];
    assign load_data = {KEY_BITS'($unsigned(record.station_key)),
                        PAYLOAD_BITS'(record.record_payload)};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_reg[IDX_W-1:0];
        wr_data = rd_b_reg;
        if (cmd.load && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = load_data;
        end
        else if (cmd.wr_a)
        begin
            wr_en   = 1'b1;
            wr_addr = row_reg[IDX_W-1:0];
            wr_data = rd_b_reg;
        end
        else if (cmd.wr_b)
        begin
            wr_en   = 1'b1;
            wr_addr = row_b[IDX_W-1:0];
            wr_data = rd_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_pair || cmd.emit_rd)
        begin
            rd_a_reg <= mem[row_reg[IDX_W-1:0]];
            rd_b_reg <= mem[row_b[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            gap_reg       <= '0;
            limit_reg     <= '0;
            lsr_reg       <= '0;
            swap_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.clear)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            if (cmd.gap_init)
            begin
                gap_reg <= count_reg >> 1;
            end
            else if (cmd.gap_half)
            begin
                gap_reg <= gap_reg >> 1;
            end
            if (cmd.limit_from_count)
            begin
                limit_reg <= count_reg - gap_reg;
            end
            else if (cmd.limit_from_lsr)
            begin
                limit_reg <= lsr_reg;
            end
            if (cmd.pass_start)
            begin
                swap_reg <= 1'b0;
                lsr_reg  <= '0;
                row_reg  <= '0;
            end
            else if (cmd.emit_init)
            begin
                row_reg <= '0;
            end
            else if (cmd.row_inc)
            begin
                row_reg <= row_plus1;
            end
            if (cmd.wr_a)
            begin
                swap_reg <= 1'b1;
                lsr_reg  <= row_reg;
            end
            out_valid_reg <= cmd.emit_rd;
            out_last_reg  <= cmd.emit_rd && (row_plus1 == count_reg);
        end
    end

    assign sts.gap_zero   = (gap_reg == '0);
    assign sts.limit_zero = (limit_reg == '0);
    assign sts.greater    = ($signed(key_a) > $signed(key_b));
    assign sts.row_end    = (row_plus1 >= limit_reg);
    assign sts.swap_seen  = swap_reg;
    assign sts.emit_end   = (row_plus1 == count_reg);

    assign result_valid          = out_valid_reg;
    assign result.sorted_key     = 32'(key_a);
    assign result.sorted_payload = 64'(rd_a_reg[PAYLOAD_BITS-1:0]);
    assign result.last_out       = out_last_reg;
    assign result.dropped        = overflow_reg;

    // pair reads stay inside the loaded rows
    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_pair |-> (row_b < count_reg))
        else $error("pair read beyond loaded rows");

    // read-out only starts on a non-empty set
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_init |-> (count_reg != '0))
        else $error("read-out of empty set");

endmodule

/* design/shell_sort_records_by_key_core.sv */
// ----------------------------------------------------------------------------
// shell_sort_records_by_key_core
// Loads keyed records, shell sorts them by signed key with a halving gap,
// and streams them out in ascending key order.
// ----------------------------------------------------------------------------
//  channel   handshake              beat
//  record    start & !busy          station_key, record_payload, last_record
//  result    result_valid (strobe)  sorted_key, sorted_payload, last_out, dropped
//
//  Load: one record per cycle while busy is low.
//  Sort: each compare reads the pair, then compares; a swap writes row a, then row b,
//  as the record store has a single write port; each pass and gap step adds control states.
//  Read-out: one result per cycle for count records, then a finish state before idle.
//  Reset clears control and counters; the record store is not cleared.
//  Results cannot be stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
module shell_sort_records_by_key_core #(
    parameter int DEPTH        = ssr_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ssr_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ssr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssr_pkg::ssr_rec_t record,
    output logic              result_valid,
    output ssr_pkg::ssr_res_t result
);

    ssr_pkg::ssr_cmd_t cmd;
    ssr_pkg::ssr_sts_t sts;

    ssr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_record (record.last_record),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy)
    );

    ssr_dpath #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .record       (record),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    // a set ends only after its flagged final beat
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(result_valid && result.last_out))
        else $error("busy dropped without final result");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed-record shell sort core.
// Record sets are loaded one beat at a time in bursts with random gaps. The
// bench keeps its own copy of the record store and runs the same halving-gap
// shell sort on each set, so the order of equal keys is predicted exactly.
// Every result beat is checked field by field against the oldest predicted
// beat. Directed sets cover single records, key extremes, equal keys and
// pairs; random sets cover small, full and overflowing sets.
// ----------------------------------------------------------------------------
module tb;

    localparam int STORE_DEPTH    = ssr_pkg::DEPTH_DEF;
    localparam int ITEM_TARGET    = 360;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_EXTREME,
        KEYS_RISING,
        KEYS_FALLING
    } key_mix_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    ssr_pkg::ssr_rec_t record;
    logic              result_valid;
    ssr_pkg::ssr_res_t result;

    logic signed [31:0] held_key [STORE_DEPTH];
    logic [63:0]        held_payload [STORE_DEPTH];
    int                 held_count;
    bit                 held_overflow;

    ssr_pkg::ssr_res_t sorted_records_q [$];
    ssr_pkg::ssr_rec_t set_buf [$];

    int errors;
    int items_sent;
    int burst_left;
    bit idle_on;
    int idle_cycles;

    shell_sort_records_by_key_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .record       (record),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Halving-gap shell sort over the held records, same pass limits as the core.
    task automatic sort_held_records();
        int                 n;
        int                 g;
        int                 limit;
        int                 last_swap;
        int                 row;
        bit                 swapped;
        logic signed [31:0] tk;
        logic [63:0]        tp;
        n = held_count;
        g = n / 2;
        while (g > 0)
        begin
            limit = n - g;
            do
            begin
                swapped   = 1'b0;
                last_swap = 0;
                for (row = 0; row < limit; row++)
                begin
                    if (held_key[row] > held_key[row + g])
                    begin
                        tk                     = held_key[row];
                        tp                     = held_payload[row];
                        held_key[row]          = held_key[row + g];
                        held_payload[row]      = held_payload[row + g];
                        held_key[row + g]      = tk;
                        held_payload[row + g]  = tp;
                        last_swap              = row;
                        swapped                = 1'b1;
                    end
                end
                limit = last_swap;
            end
            while (swapped);
            g = g / 2;
        end
    endtask

    task automatic take_record(input ssr_pkg::ssr_rec_t r);
        ssr_pkg::ssr_res_t exp_beat;
        int                i;
        if (held_count < STORE_DEPTH)
        begin
            held_key[held_count]     = r.station_key;
            held_payload[held_count] = r.record_payload;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (r.last_record)
        begin
            sort_held_records();
            for (i = 0; i < held_count; i++)
            begin
                exp_beat.sorted_key     = held_key[i];
                exp_beat.sorted_payload = held_payload[i];
                exp_beat.last_out       = (i == held_count - 1);
                exp_beat.dropped        = held_overflow;
                sorted_records_q.push_back(exp_beat);
            end
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    task automatic send_rec(input ssr_pkg::ssr_rec_t r);
        int gap_len;
        if (burst_left == 0)
        begin
            gap_len = idle_on ? $urandom_range(0, 4) : 0;
            if (gap_len > 0)
            begin
                start <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start  <= 1'b1;
        record <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_record(r);
        items_sent++;
    endtask

    task automatic send_set();
        int i;
        for (i = 0; i < set_buf.size(); i++)
        begin
            set_buf[i].last_record = (i == set_buf.size() - 1);
            send_rec(set_buf[i]);
        end
        set_buf.delete();
    endtask

    task automatic add_rec(input logic signed [31:0] key, input logic [63:0] payload);
        ssr_pkg::ssr_rec_t r;
        r.station_key    = key;
        r.record_payload = payload;
        r.last_record    = 1'b0;
        set_buf.push_back(r);
    endtask

    function automatic logic [63:0] rand_payload();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic signed [31:0] rand_key(input key_mix_t mix, input int idx,
                                                    input logic signed [31:0] base);
        case (mix)
            KEYS_NARROW:  return $signed($urandom_range(0, 7)) - 4;
            KEYS_EXTREME:
                case ($urandom_range(0, 5))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    2:       return KEY_MIN + 1;
                    3:       return KEY_MAX - 1;
                    4:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            KEYS_RISING:  return base + idx;
            KEYS_FALLING: return base - idx;
            default:      return $urandom();
        endcase
    endfunction

    task automatic test_single_record();
        idle_on = 1'b1;
        add_rec(KEY_MAX, 64'hffff_ffff_ffff_ffff);
        send_set();
        add_rec(KEY_MIN, 64'h0);
        send_set();
    endtask

    task automatic test_key_extremes();
        idle_on = 1'b0;
        add_rec(KEY_MAX,       64'hffff_ffff_ffff_ffff);
        add_rec(KEY_MIN,       64'h0000_0000_0000_0000);
        add_rec(32'sd0,        64'haaaa_aaaa_aaaa_aaaa);
        add_rec(-32'sd1,       64'h5555_5555_5555_5555);
        add_rec(32'sd1,        64'h8000_0000_0000_0001);
        add_rec(KEY_MIN + 1,   64'h0123_4567_89ab_cdef);
        add_rec(KEY_MAX - 1,   64'hfedc_ba98_7654_3210);
        send_set();
    endtask

    task automatic test_equal_keys();
        int i;
        idle_on = 1'b1;
        for (i = 0; i < 6; i++)
            add_rec(32'sd5, 64'(i + 1));
        add_rec(-32'sd5, 64'hdead_beef_0000_0007);
        send_set();
    endtask

    task automatic test_pairs();
        idle_on = 1'b0;
        add_rec(32'sd100, 64'h1);
        add_rec(-32'sd100, 64'h2);
        send_set();
        add_rec(-32'sd7, 64'h3);
        add_rec(32'sd7, 64'h4);
        send_set();
    endtask

    task automatic test_random_sets();
        int          set_idx;
        int          set_len;
        int          i;
        key_mix_t    mix;
        logic signed [31:0] base;
        set_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // store full, then store overflowing (flagged record dropped too)
            if (set_idx == 0)
                set_len = STORE_DEPTH;
            else if (set_idx == 1)
                set_len = STORE_DEPTH + 2;
            else if ($urandom_range(0, 11) == 0)
                set_len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 4);
            else
                set_len = $urandom_range(1, 12);
            mix     = key_mix_t'($urandom_range(0, 4));
            base    = $urandom();
            idle_on = ($urandom_range(0, 3) != 0);
            for (i = 0; i < set_len; i++)
                add_rec(rand_key(mix, i, base), rand_payload());
            send_set();
            set_idx++;
        end
    endtask

    always @(posedge clk)
    begin
        ssr_pkg::ssr_res_t exp_beat;
        if (rst_n && result_valid)
        begin
            if (sorted_records_q.size() == 0)
            begin
                $display("%0t: unexpected result beat key=%0d payload=%h", $time,
                         result.sorted_key, result.sorted_payload);
                errors++;
            end
            else
            begin
                exp_beat = sorted_records_q.pop_front();
                if (result.sorted_key !== exp_beat.sorted_key)
                begin
                    $display("%0t: sorted_key expected %0d got %0d", $time,
                             exp_beat.sorted_key, result.sorted_key);
                    errors++;
                end
                if (result.sorted_payload !== exp_beat.sorted_payload)
                begin
                    $display("%0t: sorted_payload expected %h got %h", $time,
                             exp_beat.sorted_payload, result.sorted_payload);
                    errors++;
                end
                if (result.last_out !== exp_beat.last_out)
                begin
                    $display("%0t: last_out expected %b got %b", $time,
                             exp_beat.last_out, result.last_out);
                    errors++;
                end
                if (result.dropped !== exp_beat.dropped)
                begin
                    $display("%0t: dropped expected %b got %b", $time,
                             exp_beat.dropped, result.dropped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        items_sent    = 0;
        burst_left    = 0;
        idle_on       = 1'b0;
        idle_cycles   = 0;
        held_count    = 0;
        held_overflow = 1'b0;
        rst_n  <= 1'b0;
        start  <= 1'b0;
        record <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_record();
        test_key_extremes();
        test_equal_keys();
        test_pairs();
        test_random_sets();

        start <= 1'b0;
        while (sorted_records_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
design/ssr_pkg.sv
design/ssr_ctrl.sv
design/ssr_dpath.sv
design/shell_sort_records_by_key_core.sv
dv/tb.sv
